@@ hdl/rsh_pkg.sv @@
// shared types and constants for the ray/sphere hit and sky gradient shader
// no dependencies; imported by every module of the block
`default_nettype none
package rsh_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W       = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;

    // register reset values
    localparam logic signed [15:0] CENTER_X_RST = 16'sd0;
    localparam logic signed [15:0] CENTER_Y_RST = 16'sd0;
    localparam logic signed [15:0] CENTER_Z_RST = -16'sd4096;
    localparam logic [14:0]        RADIUS_RST   = 15'd2048;

    // integer square root of a 48 bit value, one result bit per stage
    localparam int unsigned SQ_STAGES = 24;

    // reciprocal of 5 for the green blend, exact for values below 2^30
    localparam int unsigned RCP5_SHIFT = 30;
    localparam logic [27:0] RCP5_MULT  = 28'd214748365;

    // one ray
    typedef struct packed {
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic signed [15:0] org_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } ray_t;

    // one shaded pixel
    typedef struct packed {
        logic [12:0] red;
        logic [12:0] green;
        logic [12:0] blue;
        logic        sphere_hit;
    } pix_t;

    // side data carried through the square root stages
    typedef struct packed {
        logic        hit;
        logic        dy_neg;
        logic [15:0] dy_mag;
    } sq_tag_t;

    // side data carried through the divider stages
    typedef struct packed {
        logic hit;
        logic dy_neg;
        logic len_zero;
    } dv_tag_t;

endpackage
`default_nettype wire

@@ hdl/rsh_disc.sv @@
// discriminant sign test: six register stages from ray to hit flag
// depends on rsh_pkg
`default_nettype none
module rsh_disc
    import rsh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire ray_t               ray,
    input  wire logic signed [15:0] center_x,
    input  wire logic signed [15:0] center_y,
    input  wire logic signed [15:0] center_z,
    input  wire logic [14:0]        radius,
    output logic                    out_valid,
    output logic [31:0]             a_sq,
    output sq_tag_t                 tag
);

    logic [5:0] vld_reg;

    // stage 1: offsets from the center
    logic signed [16:0] ox_reg, oy_reg, oz_reg;
    logic signed [15:0] dx_reg, dy_reg, dz_reg;
    logic [14:0]        r_reg;
    logic signed [16:0] ox_next, oy_next, oz_next;

    assign ox_next = 17'(ray.org_x) - 17'(center_x);
    assign oy_next = 17'(ray.org_y) - 17'(center_y);
    assign oz_next = 17'(ray.org_z) - 17'(center_z);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
            dx_reg <= ray.dir_x;
            dy_reg <= ray.dir_y;
            dz_reg <= ray.dir_z;
            r_reg  <= radius;
        end
    end

    // stage 2: the ten products
    logic signed [31:0] ddx, ddy, ddz;
    logic signed [32:0] odx, ody, odz;
    logic signed [33:0] oox, ooy, ooz;
    logic [29:0]        rr_next;
    logic [30:0]        aa0_reg, aa1_reg, aa2_reg;
    logic signed [32:0] bb0_reg, bb1_reg, bb2_reg;
    logic [32:0]        cc0_reg, cc1_reg, cc2_reg;
    logic [29:0]        rr_reg;
    logic signed [15:0] dy2_reg;

    assign ddx = dx_reg * dx_reg;
    assign ddy = dy_reg * dy_reg;
    assign ddz = dz_reg * dz_reg;
    assign odx = ox_reg * dx_reg;
    assign ody = oy_reg * dy_reg;
    assign odz = oz_reg * dz_reg;
    assign oox = ox_reg * ox_reg;
    assign ooy = oy_reg * oy_reg;
    assign ooz = oz_reg * oz_reg;
    assign rr_next = 30'(r_reg) * 30'(r_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa0_reg <= ddx[30:0];
            aa1_reg <= ddy[30:0];
            aa2_reg <= ddz[30:0];
            bb0_reg <= odx;
            bb1_reg <= ody;
            bb2_reg <= odz;
            cc0_reg <= oox[32:0];
            cc1_reg <= ooy[32:0];
            cc2_reg <= ooz[32:0];
            rr_reg  <= rr_next;
            dy2_reg <= dy_reg;
        end
    end

    // stage 3: a, b/2 and c
    logic [31:0]        a3_reg, a3_next;
    logic signed [34:0] bh3_reg, bh3_next;
    logic signed [34:0] c3_reg, c3_next;
    logic signed [15:0] dy3_reg;

    assign a3_next  = 32'(aa0_reg) + 32'(aa1_reg) + 32'(aa2_reg);
    assign bh3_next = 35'(bb0_reg) + 35'(bb1_reg) + 35'(bb2_reg);
    assign c3_next  = $signed(35'(cc0_reg) + 35'(cc1_reg) + 35'(cc2_reg) - 35'(rr_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg  <= a3_next;
            bh3_reg <= bh3_next;
            c3_reg  <= c3_next;
            dy3_reg <= dy2_reg;
        end
    end

    // stage 4: split wide products into halves, classify the sign of c
    logic [33:0] m4, cm4;
    logic [50:0] pm_lo_reg, pm_hi_reg;
    logic [48:0] pq_lo_reg, pq_hi_reg;
    logic        cpos4_reg, pre4_reg;
    logic [31:0] a4_reg;
    logic signed [15:0] dy4_reg;
    logic        pre4_next;

    assign m4  = bh3_reg[34] ? 34'(-bh3_reg) : bh3_reg[33:0];
    assign cm4 = c3_reg[33:0];
    assign pre4_next = c3_reg[34] ? (a3_reg != '0) : (bh3_reg != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_lo_reg <= 51'(m4) * 51'(m4[16:0]);
            pm_hi_reg <= 51'(m4) * 51'(m4[33:17]);
            pq_lo_reg <= 49'(a3_reg) * 49'(cm4[16:0]);
            pq_hi_reg <= 49'(a3_reg) * 49'(cm4[33:17]);
            cpos4_reg <= !c3_reg[34] && (c3_reg != '0);
            pre4_reg  <= pre4_next;
            a4_reg    <= a3_reg;
            dy4_reg   <= dy3_reg;
        end
    end

    // stage 5: recombine the partial products
    logic [67:0] pp5_reg, qq5_reg;
    logic        cpos5_reg, pre5_reg;
    logic [31:0] a5_reg;
    logic signed [15:0] dy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp5_reg   <= 68'(pm_lo_reg) + (68'(pm_hi_reg) << 17);
            qq5_reg   <= 68'(pq_lo_reg) + (68'(pq_hi_reg) << 17);
            cpos5_reg <= cpos4_reg;
            pre5_reg  <= pre4_reg;
            a5_reg    <= a4_reg;
            dy5_reg   <= dy4_reg;
        end
    end

    // stage 6: compare (b/2)^2 against a*c
    logic        hit6_reg;
    logic [31:0] a6_reg;
    logic signed [15:0] dy6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit6_reg <= cpos5_reg ? (pp5_reg > qq5_reg) : pre5_reg;
            a6_reg   <= a5_reg;
            dy6_reg  <= dy5_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    assign out_valid  = vld_reg[5];
    assign a_sq       = a6_reg;
    assign tag.hit    = hit6_reg;
    assign tag.dy_neg = dy6_reg[15];
    assign tag.dy_mag = dy6_reg[15] ? 16'(-dy6_reg) : dy6_reg;

endmodule
`default_nettype wire

@@ hdl/rsh_sqrt.sv @@
// pipelined integer square root of a << 16, one result bit per stage
// depends on rsh_pkg
`default_nettype none
module rsh_sqrt
    import rsh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire logic [31:0] a_sq,
    input  wire sq_tag_t in_tag,
    output logic         out_valid,
    output logic [23:0]  len,
    output sq_tag_t      out_tag
);

    logic [47:0]          v_reg   [SQ_STAGES];
    logic [47:0]          res_reg [SQ_STAGES];
    sq_tag_t              tag_reg [SQ_STAGES];
    logic [SQ_STAGES-1:0] vld_reg;

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_st
        logic [47:0] v_prev, r_prev, bitv, trial, v_next, r_next;
        sq_tag_t     t_prev;
        logic        vp;

        if (k == 0)
        begin : g_first
            assign v_prev = {a_sq, 16'b0};
            assign r_prev = '0;
            assign t_prev = in_tag;
            assign vp     = in_valid;
        end
        else
        begin : g_rest
            assign v_prev = v_reg[k-1];
            assign r_prev = res_reg[k-1];
            assign t_prev = tag_reg[k-1];
            assign vp     = vld_reg[k-1];
        end

        // try the next result bit
        assign bitv  = 48'(1) << (46 - 2 * k);
        assign trial = r_prev + bitv;

        always_comb
        begin
            if (v_prev >= trial)
            begin
                v_next = v_prev - trial;
                r_next = (r_prev >> 1) + bitv;
            end
            else
            begin
                v_next = v_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]   <= v_next;
                res_reg[k] <= r_next;
                tag_reg[k] <= t_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vp;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign len       = res_reg[SQ_STAGES-1][23:0];
    assign out_tag   = tag_reg[SQ_STAGES-1];

endmodule
`default_nettype wire

@@ hdl/rsh_div.sv @@
// pipelined restoring divider for |dir_y| / |d|, one quotient bit per stage
// depends on rsh_pkg
`default_nettype none
module rsh_div
    import rsh_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [23:0]   len,
    input  wire sq_tag_t       in_tag,
    output logic               out_valid,
    output logic [FRAC_BITS:0] quo,
    output dv_tag_t            out_tag
);

    localparam int unsigned NQ = FRAC_BITS + 1;
    localparam int unsigned DW = FRAC_BITS + 24;
    localparam int unsigned QW = FRAC_BITS + 1;

    logic [DW-1:0]   rem_reg [NQ];
    logic [23:0]     len_reg [NQ];
    logic [QW-1:0]   q_reg   [NQ];
    dv_tag_t         tag_reg [NQ];
    logic [NQ-1:0]   vld_reg;

    dv_tag_t tag0;
    assign tag0.hit      = in_tag.hit;
    assign tag0.dy_neg   = in_tag.dy_neg;
    assign tag0.len_zero = (len == '0);

    for (genvar j = 0; j < NQ; j++)
    begin : g_st
        localparam int unsigned K = FRAC_BITS - j;
        logic [DW-1:0] rem_prev, dsh, rem_next;
        logic [23:0]   len_prev;
        logic [QW-1:0] q_prev, q_next;
        dv_tag_t       t_prev;
        logic          vp;

        if (j == 0)
        begin : g_first
            assign rem_prev = DW'(in_tag.dy_mag) << (FRAC_BITS + 8);
            assign len_prev = len;
            assign q_prev   = '0;
            assign t_prev   = tag0;
            assign vp       = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[j-1];
            assign len_prev = len_reg[j-1];
            assign q_prev   = q_reg[j-1];
            assign t_prev   = tag_reg[j-1];
            assign vp       = vld_reg[j-1];
        end

        // subtract the shifted divisor when it fits
        assign dsh = DW'(len_prev) << K;

        always_comb
        begin
            if (rem_prev >= dsh)
            begin
                rem_next = rem_prev - dsh;
                q_next   = q_prev | (QW'(1) << K);
            end
            else
            begin
                rem_next = rem_prev;
                q_next   = q_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                len_reg[j] <= len_prev;
                q_reg[j]   <= q_next;
                tag_reg[j] <= t_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vp;
            end
        end
    end

    assign out_valid = vld_reg[NQ-1];
    assign quo       = q_reg[NQ-1];
    assign out_tag   = tag_reg[NQ-1];

    // |y| never exceeds |d|, so the unit component stays within 1.0
    a_quo_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_tag.len_zero |-> quo <= (QW'(1) << FRAC_BITS))
        else $error("quotient above one");

endmodule
`default_nettype wire

@@ hdl/rsh_blend.sv @@
// white to sky blue blend and hit override, one register stage
// depends on rsh_pkg
`default_nettype none
module rsh_blend
    import rsh_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [FRAC_BITS:0] quo,
    input  wire dv_tag_t       in_tag,
    output logic               out_valid,
    output pix_t               pix
);

    localparam int unsigned SW = FRAC_BITS + 3;
    localparam int unsigned PW = SW + 28;
    localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

    // s = 1 + u, which is 2t
    logic [SW-1:0] s, red_next, y;
    always_comb
    begin
        if (in_tag.len_zero)
        begin
            s = ONE;
        end
        else if (in_tag.dy_neg)
        begin
            s = ONE - SW'(quo);
        end
        else
        begin
            s = ONE + SW'(quo);
        end
    end

    assign red_next = ONE - ((s + SW'(2)) >> 2);
    assign y        = (SW'(3) * s + SW'(10)) >> 2;

    // register the reciprocal product for the divide by 20
    logic [SW-1:0] red_reg;
    logic [PW-1:0] prod_reg;
    logic          hit_reg;
    logic          vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg  <= red_next;
            prod_reg <= PW'(y) * PW'(RCP5_MULT);
            hit_reg  <= in_tag.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    // finish green, apply the hit color, mask to the field width
    logic [SW-1:0] green;
    assign green = ONE - SW'(prod_reg >> RCP5_SHIFT);

    always_comb
    begin
        if (hit_reg)
        begin
            pix.red        = 13'(ONE);
            pix.green      = '0;
            pix.blue       = '0;
            pix.sphere_hit = 1'b1;
        end
        else
        begin
            pix.red        = 13'(red_reg);
            pix.green      = 13'(green);
            pix.blue       = 13'(ONE);
            pix.sphere_hit = 1'b0;
        end
    end

    assign out_valid = vld_reg;

endmodule
`default_nettype wire

@@ hdl/ray_sphere_hit_gradient_shader_unit.sv @@
// Ray/sphere hit shader. Takes one ray per cycle and returns one pixel per
// ray, in order: pure red when the ray hits the configured sphere, else a
// white to sky blue gradient on the normalized y direction. The pipeline is
// 6 stages of discriminant test, 24 of square root, FRAC_BITS + 1 of
// division, one of blending and the output register, one ray per cycle
// sustained. The whole pipeline holds while a finished pixel is not
// taken. Configuration writes are accepted in every cycle and should be
// made while no ray is in flight.
// depends on rsh_pkg, rsh_disc, rsh_sqrt, rsh_div, rsh_blend
`default_nettype none
module ray_sphere_hit_gradient_shader_unit
    import rsh_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 ray_valid,
    output logic                      ray_ready,
    input  wire ray_t                 ray,
    output logic                      pix_valid,
    input  wire logic                 pix_ready,
    output pix_t                      pix,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    // configuration registers
    logic signed [15:0] center_x_reg, center_y_reg, center_z_reg;
    logic [14:0]        radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            center_z_reg <= CENTER_Z_RST;
            radius_reg   <= RADIUS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_CENTER_Z: center_z_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    // pipeline advance: the output register is free or being emptied
    logic pix_valid_reg;
    logic en;
    assign en        = !pix_valid_reg || pix_ready;
    assign ray_ready = en;

    // discriminant test
    logic        d_valid;
    logic [31:0] d_a;
    sq_tag_t     d_tag;

    rsh_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray_valid),
        .ray       (ray),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .radius    (radius_reg),
        .out_valid (d_valid),
        .a_sq      (d_a),
        .tag       (d_tag)
    );

    // direction length
    logic        s_valid;
    logic [23:0] s_len;
    sq_tag_t     s_tag;

    rsh_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .a_sq      (d_a),
        .in_tag    (d_tag),
        .out_valid (s_valid),
        .len       (s_len),
        .out_tag   (s_tag)
    );

    // unit y component
    logic               q_valid;
    logic [FRAC_BITS:0] q_quo;
    dv_tag_t            q_tag;

    rsh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .len       (s_len),
        .in_tag    (s_tag),
        .out_valid (q_valid),
        .quo       (q_quo),
        .out_tag   (q_tag)
    );

    // color
    logic b_valid;
    pix_t b_pix;

    rsh_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .quo       (q_quo),
        .in_tag    (q_tag),
        .out_valid (b_valid),
        .pix       (b_pix)
    );

    // output register
    pix_t pix_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= b_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pix_valid_reg <= b_valid;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // a hit pixel carries no green or blue
    a_hit_red: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix.sphere_hit |-> pix.green == '0 && pix.blue == '0)
        else $error("hit pixel not pure red");

    // the sky keeps blue at one
    a_sky_blue: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix.sphere_hit |-> pix.blue == 13'((1 << FRAC_BITS)))
        else $error("sky pixel blue not one");

    // the sky blend never takes more green away than red
    a_sky_order: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix.sphere_hit && FRAC_BITS <= 12 |-> pix.green >= pix.red)
        else $error("sky green below red");

endmodule
`default_nettype wire
